// ===== rtl/ics_pkg.sv =====
// ics_pkg: shared types and constants of the inversion count stable sort unit
// used by every module of the unit and by its checker
package ics_pkg;

  localparam int unsigned SYM_W       = 8;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned CNT_W       = 11;
  localparam int unsigned COUNT_MAX   = 2047;
  localparam int unsigned MAX_LEN     = 64;
  localparam int unsigned MAX_STRINGS = 64;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned M_TDATA_W = 24;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } ics_op_e;

  typedef struct packed {
    ics_op_e          op;
    logic [SYM_W-1:0] symbol;
    logic             eos;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_SCAN,
    ST_LD_FIN,
    ST_FT_SCAN,
    ST_FT_FIN
  } ics_state_e;

endpackage

// ===== rtl/ics_front.sv =====
// ics_front: input request register that decodes stream beats into commands
// depends on ics_pkg
module ics_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ics_pkg::S_TDATA_W-1:0] s_axis_tdata,  // symbol[7:0]
  input  logic                          s_axis_tuser,  // action
  input  logic                          s_axis_tlast,
  output logic                          cmd_valid_o,
  output ics_pkg::cmd_t                 cmd_o,
  input  logic                          cmd_ready_i
);

  logic          valid_q, valid_d;
  ics_pkg::cmd_t cmd_q, cmd_d;
  logic          take;

  assign s_axis_tready = !valid_q || cmd_ready_i;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d    = 1'b1;
      cmd_d.op   = s_axis_tuser ? ics_pkg::OP_FETCH : ics_pkg::OP_LOAD;
      cmd_d.symbol = s_axis_tdata[ics_pkg::SYM_W-1:0];
      cmd_d.eos  = s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

// ===== rtl/ics_queue.sv =====
// ics_queue: short command queue between the front and the back
// depends on ics_pkg
module ics_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  ics_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output ics_pkg::cmd_t pop_cmd_o
);

  localparam int unsigned PTR_W = (ics_pkg::QUEUE_DEPTH > 1) ? $clog2(ics_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(ics_pkg::QUEUE_DEPTH + 1);

  ics_pkg::cmd_t       slot_q [ics_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic                push, pop;

  assign push_ready_o = fill_q != FILL_W'(ics_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = fill_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(ics_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(ics_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== rtl/ics_back.sv =====
// ics_back: executes load and fetch commands over the symbol, count and mark memories
// depends on ics_pkg
module ics_back #(
  parameter int unsigned MAX_LEN     = ics_pkg::MAX_LEN,
  parameter int unsigned MAX_STRINGS = ics_pkg::MAX_STRINGS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  ics_pkg::cmd_t                 cmd_i,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ics_pkg::M_TDATA_W-1:0] m_axis_tdata,  // position[5:0] count[16:6] overflow[17]
  output logic                          m_axis_tuser,  // valid_res
  output logic                          m_axis_tlast
);

  localparam int unsigned LEN_IW = $clog2(MAX_LEN);
  localparam int unsigned LEN_CW = $clog2(MAX_LEN + 1);
  localparam int unsigned STR_IW = $clog2(MAX_STRINGS);
  localparam int unsigned STR_CW = $clog2(MAX_STRINGS + 1);
  localparam int unsigned CNT_W  = ics_pkg::CNT_W;
  localparam int unsigned POS_W  = ics_pkg::POS_W;
  localparam int unsigned SYM_W  = ics_pkg::SYM_W;

  ics_pkg::ics_state_e state_q, state_d;
  ics_pkg::cmd_t       cmd_q, cmd_d;

  logic [LEN_CW-1:0] len_q, len_d;
  logic [CNT_W-1:0]  cur_cnt_q, cur_cnt_d;
  logic [STR_CW-1:0] total_q, total_d;
  logic [STR_CW-1:0] fetched_q, fetched_d;
  logic              ovf_q, ovf_d;

  logic [LEN_CW-1:0] lidx_q, lidx_d;
  logic [LEN_CW-1:0] greater_q, greater_d;
  logic [STR_CW-1:0] fidx_q, fidx_d;
  logic [STR_IW-1:0] rd_idx_q, rd_idx_d;
  logic              rd_vld_q, rd_vld_d;
  logic              found_q, found_d;
  logic [CNT_W-1:0]  best_cnt_q, best_cnt_d;
  logic [STR_IW-1:0] best_pos_q, best_pos_d;

  logic [SYM_W-1:0]  sym_mem [MAX_LEN];
  logic [CNT_W-1:0]  cnt_mem [MAX_STRINGS];
  logic              mark_mem [MAX_STRINGS];
  logic [SYM_W-1:0]  sym_rd_q;
  logic [CNT_W-1:0]  cnt_rd_q;
  logic              mark_rd_q;
  logic              sym_rd_en, sym_wr_en, cnt_rd_en, cnt_wr_en;
  logic [CNT_W-1:0]  cnt_wr_data;
  logic              mark_set;

  logic                          out_valid_q, out_valid_d;
  logic [ics_pkg::M_TDATA_W-1:0] out_data_q, out_data_d;
  logic                          out_user_q, out_user_d;
  logic                          out_last_q, out_last_d;

  logic              set_full, len_room, out_free, is_last;
  logic [CNT_W:0]    sum;
  logic [CNT_W-1:0]  sat_cnt;
  logic [POS_W+STR_IW-1:0] pos_ext;

  assign set_full = total_q == STR_CW'(MAX_STRINGS);
  assign len_room = len_q < LEN_CW'(MAX_LEN);
  assign out_free = !out_valid_q || m_axis_tready;
  assign sum      = {1'b0, cur_cnt_q} + (CNT_W + 1)'(greater_q);
  assign sat_cnt  = (sum > (CNT_W + 1)'(ics_pkg::COUNT_MAX)) ?
                    CNT_W'(ics_pkg::COUNT_MAX) : sum[CNT_W-1:0];
  assign is_last  = (fetched_q + 1'b1) == total_q;
  assign pos_ext  = {{POS_W{1'b0}}, best_pos_q};

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    cur_cnt_d   = cur_cnt_q;
    total_d     = total_q;
    fetched_d   = fetched_q;
    ovf_d       = ovf_q;
    lidx_d      = lidx_q;
    greater_d   = greater_q;
    fidx_d      = fidx_q;
    rd_idx_d    = rd_idx_q;
    rd_vld_d    = 1'b0;
    found_d     = found_q;
    best_cnt_d  = best_cnt_q;
    best_pos_d  = best_pos_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    out_last_d  = out_last_q;
    sym_rd_en   = 1'b0;
    sym_wr_en   = 1'b0;
    cnt_rd_en   = 1'b0;
    cnt_wr_en   = 1'b0;
    cnt_wr_data = sat_cnt;
    mark_set    = 1'b0;
    cmd_ready_o = 1'b0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ics_pkg::ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d     = cmd_i;
          lidx_d    = '0;
          greater_d = '0;
          fidx_d    = '0;
          found_d   = 1'b0;
          if (cmd_i.op == ics_pkg::OP_LOAD) begin
            state_d = (!set_full && len_room) ? ics_pkg::ST_LD_SCAN : ics_pkg::ST_LD_FIN;
          end else begin
            state_d = ics_pkg::ST_FT_SCAN;
          end
        end
      end
      ics_pkg::ST_LD_SCAN: begin
        if (lidx_q < len_q) begin
          sym_rd_en = 1'b1;
          rd_vld_d  = 1'b1;
          lidx_d    = lidx_q + 1'b1;
        end
        if (rd_vld_q && (sym_rd_q > cmd_q.symbol)) begin
          greater_d = greater_q + 1'b1;
        end
        if ((lidx_q == len_q) && !rd_vld_q) begin
          state_d = ics_pkg::ST_LD_FIN;
        end
      end
      ics_pkg::ST_LD_FIN: begin
        if (set_full) begin
          ovf_d = 1'b1;
        end else begin
          if (len_room) begin
            sym_wr_en = 1'b1;
            cur_cnt_d = sat_cnt;
            len_d     = len_q + 1'b1;
          end else begin
            ovf_d       = 1'b1;
            cnt_wr_data = cur_cnt_q;
          end
          if (cmd_q.eos) begin
            cnt_wr_en = 1'b1;
            total_d   = total_q + 1'b1;
            len_d     = '0;
            cur_cnt_d = '0;
          end
        end
        state_d = ics_pkg::ST_IDLE;
      end
      ics_pkg::ST_FT_SCAN: begin
        if (fidx_q < total_q) begin
          cnt_rd_en = 1'b1;
          rd_vld_d  = 1'b1;
          rd_idx_d  = fidx_q[STR_IW-1:0];
          fidx_d    = fidx_q + 1'b1;
        end
        if (rd_vld_q && !mark_rd_q && (!found_q || (cnt_rd_q < best_cnt_q))) begin
          found_d    = 1'b1;
          best_cnt_d = cnt_rd_q;
          best_pos_d = rd_idx_q;
        end
        if ((fidx_q == total_q) && !rd_vld_q) begin
          state_d = ics_pkg::ST_FT_FIN;
        end
      end
      ics_pkg::ST_FT_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_user_d  = found_q;
          if (found_q) begin
            out_data_d = {{(ics_pkg::M_TDATA_W - POS_W - CNT_W - 1){1'b0}},
                          ovf_q, best_cnt_q, pos_ext[POS_W-1:0]};
            out_last_d = is_last;
            mark_set   = 1'b1;
            fetched_d  = fetched_q + 1'b1;
            if (is_last) begin
              total_d   = '0;
              fetched_d = '0;
              ovf_d     = 1'b0;
            end
          end else begin
            out_data_d = {{(ics_pkg::M_TDATA_W - POS_W - CNT_W - 1){1'b0}},
                          ovf_q, {(CNT_W + POS_W){1'b0}}};
            out_last_d = 1'b0;
          end
          state_d = ics_pkg::ST_IDLE;
        end
      end
      default: state_d = ics_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ics_pkg::ST_IDLE;
      len_q       <= '0;
      cur_cnt_q   <= '0;
      total_q     <= '0;
      fetched_q   <= '0;
      ovf_q       <= 1'b0;
      lidx_q      <= '0;
      greater_q   <= '0;
      fidx_q      <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      cur_cnt_q   <= cur_cnt_d;
      total_q     <= total_d;
      fetched_q   <= fetched_d;
      ovf_q       <= ovf_d;
      lidx_q      <= lidx_d;
      greater_q   <= greater_d;
      fidx_q      <= fidx_d;
      rd_vld_q    <= rd_vld_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    rd_idx_q   <= rd_idx_d;
    best_cnt_q <= best_cnt_d;
    best_pos_q <= best_pos_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
    out_last_q <= out_last_d;
  end

  // symbol store of the string being loaded
  always_ff @(posedge clk_i) begin
    if (sym_wr_en) begin
      sym_mem[len_q[LEN_IW-1:0]] <= cmd_q.symbol;
    end
    if (sym_rd_en) begin
      sym_rd_q <= sym_mem[lidx_q[LEN_IW-1:0]];
    end
  end

  // finished counts by arrival position
  always_ff @(posedge clk_i) begin
    if (cnt_wr_en) begin
      cnt_mem[total_q[STR_IW-1:0]] <= cnt_wr_data;
    end
    if (cnt_rd_en) begin
      cnt_rd_q <= cnt_mem[fidx_q[STR_IW-1:0]];
    end
  end

  // fetched marks, written clear when a string joins the set
  always_ff @(posedge clk_i) begin
    if (cnt_wr_en) begin
      mark_mem[total_q[STR_IW-1:0]] <= 1'b0;
    end else if (mark_set) begin
      mark_mem[best_pos_q] <= 1'b1;
    end
    if (cnt_rd_en) begin
      mark_rd_q <= mark_mem[fidx_q[STR_IW-1:0]];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== rtl/inversion_count_stable_sort_unit.sv =====
// inversion_count_stable_sort_unit: a load of a symbol compares it against the symbols stored so far
// for the current string (one stored symbol compared per cycle through the symbol memory port);
// a fetch scans the counts of the strings in the set (one count read per cycle).
// requests pass a front register and a two-entry queue before they reach the back end.
// reset: async active low, clears control, totals and flags; memories are not cleared,
// a fetched mark is written clear when its string joins the set
module inversion_count_stable_sort_unit #(
  parameter int unsigned MAX_LEN     = ics_pkg::MAX_LEN,
  parameter int unsigned MAX_STRINGS = ics_pkg::MAX_STRINGS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ics_pkg::S_TDATA_W-1:0] s_axis_tdata,  // symbol[7:0]
  input  logic                          s_axis_tuser,  // action
  input  logic                          s_axis_tlast,  // end_of_string
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ics_pkg::M_TDATA_W-1:0] m_axis_tdata,  // position[5:0] count[16:6] overflow[17]
  output logic                          m_axis_tuser,  // valid_res
  output logic                          m_axis_tlast   // last_entry
);

  logic          f_valid, f_ready, q_valid, q_ready;
  ics_pkg::cmd_t f_cmd, q_cmd;

  ics_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .cmd_valid_o   (f_valid),
    .cmd_o         (f_cmd),
    .cmd_ready_i   (f_ready)
  );

  ics_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_cmd_i   (f_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_cmd_o    (q_cmd)
  );

  ics_back #(
    .MAX_LEN     (MAX_LEN),
    .MAX_STRINGS (MAX_STRINGS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_ready_o   (q_ready),
    .cmd_i         (q_cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== rtl/ics_checker.sv =====
// ics_checker: port level checks of the inversion count stable sort unit
// depends on ics_pkg; bound to inversion_count_stable_sort_unit
module ics_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [ics_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tuser,
  input logic                          m_axis_tlast
);

  localparam int unsigned PAY_W = ics_pkg::POS_W + ics_pkg::CNT_W;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result dropped or changed while stalled");

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("last mark on an empty set result");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[PAY_W-1:0] == '0 && !m_axis_tlast)
    else $error("empty set result carries a position or count");

  a_ready_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> s_axis_tready)
    else $error("input not ready after reset");

endmodule

bind inversion_count_stable_sort_unit ics_checker u_ics_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/inversion_count_stable_sort_unit_test.sv =====
// inversion_count_stable_sort_unit_test: self-checking bench for the inversion count stable sort
// unit; load and fetch requests go through a local ranking predictor, and fetch results are
// checked field by field. depends on ics_pkg and inversion_count_stable_sort_unit
`timescale 1ns / 1ps

module inversion_count_stable_sort_unit_test;

  localparam int unsigned REQUEST_TARGET = 1600;
  localparam int unsigned HOLD_CYCLES    = 3000;
  localparam int unsigned STALL_LIMIT    = 20000;
  localparam int unsigned TAIL_CYCLES    = 300;

  typedef enum int {
    PAT_RANDOM,
    PAT_DNA,
    PAT_FALLING,
    PAT_RISING
  } sym_pattern_e;

  typedef struct packed {
    logic                      hit;
    logic [ics_pkg::POS_W-1:0] pos;
    logic [ics_pkg::CNT_W-1:0] cnt;
    logic                      last;
    logic                      ovf;
  } sort_entry_t;

  typedef struct {
    ics_pkg::ics_op_e          op;
    logic [ics_pkg::SYM_W-1:0] sym;
    logic                      eos;
    bit                        typed;
    sort_entry_t               res;
  } stim_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [ics_pkg::S_TDATA_W-1:0] s_axis_tdata;   // symbol[7:0]
  logic                          s_axis_tuser;   // action
  logic                          s_axis_tlast;   // end_of_string
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [ics_pkg::M_TDATA_W-1:0] m_axis_tdata;   // position[5:0] count[16:6] overflow[17]
  logic                          m_axis_tuser;   // valid_res
  logic                          m_axis_tlast;   // last_entry

  // predictor state
  logic [ics_pkg::SYM_W-1:0] sym_store [ics_pkg::MAX_LEN];
  logic [ics_pkg::CNT_W-1:0] cnt_store [ics_pkg::MAX_STRINGS];
  bit               taken     [ics_pkg::MAX_STRINGS] = '{default: 1'b0};
  int unsigned      cur_len     = 0;
  int unsigned      cur_cnt     = 0;
  int unsigned      set_total   = 0;
  int unsigned      taken_total = 0;
  bit               drop_flag   = 1'b0;

  sort_entry_t sorted_entries_due [$];
  int unsigned mismatches        = 0;
  int unsigned requests_sent     = 0;
  int unsigned burst_left        = 0;
  int unsigned idle_cycles       = 0;
  bit          hold_off_pending  = 1'b0;

  stim_row_t directed_rows [20] = '{
    '{ics_pkg::OP_FETCH, 8'h00, 1'b0, 1'b1, '0},
    '{ics_pkg::OP_LOAD,  8'hff, 1'b0, 1'b0, '0},
    '{ics_pkg::OP_LOAD,  8'h00, 1'b1, 1'b0, '0},
    '{ics_pkg::OP_LOAD,  8'h00, 1'b1, 1'b0, '0},
    '{ics_pkg::OP_LOAD,  8'h80, 1'b0, 1'b0, '0},
    '{ics_pkg::OP_LOAD,  8'h80, 1'b1, 1'b0, '0},
    '{ics_pkg::OP_LOAD,  8'h7f, 1'b0, 1'b0, '0},
    '{ics_pkg::OP_LOAD,  8'hfe, 1'b0, 1'b0, '0},
    '{ics_pkg::OP_LOAD,  8'h01, 1'b0, 1'b0, '0},
    '{ics_pkg::OP_LOAD,  8'h55, 1'b1, 1'b0, '0},
    '{ics_pkg::OP_FETCH, 8'h00, 1'b0, 1'b0, '0},
    '{ics_pkg::OP_LOAD,  8'haa, 1'b1, 1'b0, '0},
    '{ics_pkg::OP_FETCH, 8'hff, 1'b1, 1'b0, '0},
    '{ics_pkg::OP_FETCH, 8'h00, 1'b0, 1'b0, '0},
    '{ics_pkg::OP_FETCH, 8'h00, 1'b0, 1'b0, '0},
    '{ics_pkg::OP_LOAD,  8'h33, 1'b0, 1'b0, '0},
    '{ics_pkg::OP_FETCH, 8'h00, 1'b0, 1'b0, '0},
    '{ics_pkg::OP_LOAD,  8'h11, 1'b1, 1'b0, '0},
    '{ics_pkg::OP_FETCH, 8'h00, 1'b0, 1'b0, '0},
    '{ics_pkg::OP_FETCH, 8'h00, 1'b0, 1'b1, '0}
  };

  inversion_count_stable_sort_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  // ranks one accepted request, returns 1 when it yields a fetch result
  function automatic bit rank_request(input ics_pkg::ics_op_e op,
                                      input logic [ics_pkg::SYM_W-1:0] sym,
                                      input logic eos, output sort_entry_t res);
    int unsigned greater;
    int          best;
    res = '0;
    if (op == ics_pkg::OP_LOAD) begin
      if (set_total >= ics_pkg::MAX_STRINGS) begin
        drop_flag = 1'b1;
        return 1'b0;
      end
      if (cur_len < ics_pkg::MAX_LEN) begin
        greater = 0;
        for (int k = 0; k < cur_len; k++) begin
          if (sym_store[k] > sym) greater++;
        end
        cur_cnt = (cur_cnt + greater > ics_pkg::COUNT_MAX) ? ics_pkg::COUNT_MAX
                                                           : cur_cnt + greater;
        sym_store[cur_len] = sym;
        cur_len++;
      end else begin
        drop_flag = 1'b1;
      end
      if (eos) begin
        cnt_store[set_total] = ics_pkg::CNT_W'(cur_cnt);
        set_total++;
        cur_len = 0;
        cur_cnt = 0;
      end
      return 1'b0;
    end
    best = -1;
    for (int k = 0; k < set_total; k++) begin
      if (!taken[k] && (best < 0 || cnt_store[k] < cnt_store[best])) best = k;
    end
    res.ovf = drop_flag;
    if (best < 0) return 1'b1;
    taken[best] = 1'b1;
    taken_total++;
    res.hit = 1'b1;
    res.pos = ics_pkg::POS_W'(best);
    res.cnt = cnt_store[best];
    if (taken_total >= set_total) begin
      res.last    = 1'b1;
      taken       = '{default: 1'b0};
      set_total   = 0;
      taken_total = 0;
      drop_flag   = 1'b0;
    end
    return 1'b1;
  endfunction

  // offers one request in bursts with random gaps, entered and left at a falling edge
  task automatic offer(input ics_pkg::ics_op_e op, input logic [ics_pkg::SYM_W-1:0] sym,
                       input logic eos, input bit typed = 1'b0,
                       input sort_entry_t typed_res = '0);
    sort_entry_t res;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= sym;
    s_axis_tlast  <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
    if (rank_request(op, sym, eos, res)) begin
      sorted_entries_due = {sorted_entries_due, typed ? typed_res : res};
    end
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (sorted_entries_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic load_string(input int unsigned len, input sym_pattern_e pat);
    logic [ics_pkg::SYM_W-1:0] sym;
    logic [ics_pkg::SYM_W-1:0] dna [4] = '{8'h41, 8'h43, 8'h47, 8'h54};
    for (int unsigned i = 0; i < len; i++) begin
      case (pat)
        PAT_DNA:     sym = dna[$urandom_range(0, 3)];
        PAT_FALLING: sym = ics_pkg::SYM_W'(255 - i);
        PAT_RISING:  sym = ics_pkg::SYM_W'(i * 3);
        default:     sym = ics_pkg::SYM_W'($urandom_range(0, 255));
      endcase
      offer(ics_pkg::OP_LOAD, sym, i == len - 1);
    end
  endtask

  // fetches until the set clears, or stops early now and then when allowed
  task automatic fetch_set(input bit may_stop);
    do offer(ics_pkg::OP_FETCH, ics_pkg::SYM_W'($urandom_range(0, 255)),
             1'(($urandom_range(0, 1))));
    while (set_total != 0 && !(may_stop && $urandom_range(0, 11) == 0));
  endtask

  task automatic random_set();
    int unsigned n_str;
    int unsigned len;
    n_str = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
    for (int unsigned s = 0; s < n_str; s++) begin
      len = ($urandom_range(0, 39) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
      load_string(len, sym_pattern_e'($urandom_range(0, 3)));
      if ($urandom_range(0, 5) == 0) offer(ics_pkg::OP_FETCH, 8'h00, 1'b0);
    end
    fetch_set(1'b1);
    if ($urandom_range(0, 3) == 0) offer(ics_pkg::OP_FETCH, 8'h00, 1'b0);
  endtask

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int unsigned pat;
    int unsigned pat_left;
    pat = 0;
    pat_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      if (pat_left == 0) begin
        pat = $urandom_range(0, 3);
        pat_left = $urandom_range(20, 300);
      end
      pat_left--;
      case (pat)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= ($urandom_range(0, 7) != 0);
        default: m_axis_tready <= (pat_left % 5 == 0);
      endcase
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    sort_entry_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (sorted_entries_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tdata %h tuser %b tlast %b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        mismatches++;
      end else begin
        want = sorted_entries_due.pop_front();
        check_field("valid_res", want.hit, m_axis_tuser);
        check_field("original_position", want.pos, m_axis_tdata[5:0]);
        check_field("inversion_count", want.cnt, m_axis_tdata[16:6]);
        check_field("overflow", want.ovf, m_axis_tdata[17]);
        check_field("tdata padding", 0, m_axis_tdata[ics_pkg::M_TDATA_W-1:18]);
        check_field("last_entry", want.last, m_axis_tlast);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no request accepted for %0d cycles", $time, STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      offer(directed_rows[i].op, directed_rows[i].sym, directed_rows[i].eos,
            directed_rows[i].typed, directed_rows[i].res);
    end
    wait_drain();

    // overlong falling string: dropped symbols and the largest count
    load_string(70, PAT_FALLING);
    fetch_set(1'b0);
    // full set plus dropped strings while the receiver holds off
    hold_off_pending = 1'b1;
    for (int s = 0; s < ics_pkg::MAX_STRINGS + 2; s++) load_string(1, PAT_RANDOM);
    fetch_set(1'b0);
    wait_drain();

    while (requests_sent < REQUEST_TARGET) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 8)) begin
          offer(ics_pkg::ics_op_e'($urandom_range(0, 1)),
                ics_pkg::SYM_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
      end else begin
        random_set();
      end
      if ($urandom_range(0, 19) == 0) wait_drain();
    end

    wait_drain();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && sorted_entries_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ics_pkg.sv
rtl/ics_front.sv
rtl/ics_queue.sv
rtl/ics_back.sv
rtl/inversion_count_stable_sort_unit.sv
rtl/ics_checker.sv
tb/inversion_count_stable_sort_unit_test.sv
